FILE: rtl/sbseg_pkg.sv
// Shared types and constants for the scan breakpoint segmenter.
// No dependencies; imported by scan_breakpoint_segmenter_core.
`timescale 1ns / 1ps
`default_nettype none

package sbseg_pkg;

    localparam int MAX_BEAMS  = 2048;
    localparam int BEAM_W     = $clog2(MAX_BEAMS);
    localparam int IDX_W      = 11;
    localparam int RANGE_W    = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [BEAM_W-1:0] BEAM_LAST = BEAM_W'(MAX_BEAMS - 1);
    localparam logic [IDX_W-1:0]  PAIR_MAX  = {IDX_W{1'b1}};

    localparam logic [CFG_W-1:0] THRESH_RESET = 32'd10000;
    localparam logic [IDX_W-1:0] MINPR_RESET  = 11'd5;
    localparam logic [CFG_W-1:0] COSF_RESET   = 32'd81780;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST_SQ_THRESHOLD   = 2'd0,
        CFG_MIN_PAIRS           = 2'd1,
        CFG_TWICE_ONE_MINUS_COS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_AB     = 2'd1,
        S_CROSS  = 2'd2,
        S_DECIDE = 2'd3
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/scan_breakpoint_segmenter_core.sv
// Breakpoint segmenter for laser range scans, top level.
// Depends on sbseg_pkg (types, widths, register reset values).
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_* : one beam per word. tdata = range in mm, tuser = range valid,
//         tlast = final beam of the scan.
//   m_* : one word per reported segment or final beam of a scan (one
//         word if both). tuser = segment kept, tlast = scan done.
//   cfg_* : register writes (0 threshold, 1 min pairs, 2 cosine factor);
//         always ready, write only while the block is idle.
// One 32x32 multiplier is shared: |dr|^2 in the accept cycle, r1*r2 next,
// then the product with the cosine factor, and the compare and segment
// update in the decide step. A new beam is accepted only once the last
// one's decide step commits; its result is registered then and shown on
// m_tvalid in the cycle after. The output register lets a new beam be
// accepted while a result waits; if the receiver stalls, the next beam
// that has a result holds in its final cycle until the waiting word is
// taken.
// Reset: registers return to their reset values, scan state clears, and
// the block is ready as soon as reset is released.
module scan_breakpoint_segmenter_core
    import sbseg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [RANGE_W-1:0]    s_tdata,   // [15:0] range_mm
    input  wire logic                  s_tuser,   // [0] range_valid
    input  wire logic                  s_tlast,   // scan_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [10:0] seg_first, [21:11] seg_final,
                                                  // [32:22] seg_pairs, [39:33] zero
    output logic                       m_tuser,   // [0] seg_valid
    output logic                       m_tlast,   // scan_done
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    // configuration
    logic [CFG_W-1:0] thresh_reg;
    logic [IDX_W-1:0] min_pairs_reg;
    logic [CFG_W-1:0] cosf_reg;

    // sequencer
    state_t state_reg, state_next;

    // beam being worked on
    logic [RANGE_W-1:0] r_reg;
    logic               ok_reg;
    logic               last_reg;

    // arithmetic
    logic [2*CFG_W-1:0] mul_p;
    logic [CFG_W-1:0]   mul_a, mul_b;
    logic [RANGE_W-1:0] diff;
    logic [CFG_W-1:0]   sq_reg, ab_reg, cross_reg;
    logic [CFG_W:0]     dist_sq;

    // scan state
    logic [RANGE_W-1:0] prev_range_reg, prev_range_next;
    logic               prev_ok_reg, prev_ok_next;
    logic [BEAM_W-1:0]  beam_index_reg, beam_index_next;
    logic               in_segment_reg, in_segment_next;
    logic [BEAM_W-1:0]  open_start_reg, open_start_next;
    logic [IDX_W-1:0]   pair_count_reg, pair_count_next;

    // result
    logic               kept;
    logic [BEAM_W-1:0]  k_first, k_final;
    logic [IDX_W-1:0]   k_pairs;
    logic               join_ok;
    logic               emit;
    logic               out_free;
    logic               commit;

    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               out_user_reg;
    logic               out_last_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign m_tlast   = out_last_reg;

    // shared multiplier, operands picked by state
    assign diff = (s_tdata > prev_range_reg) ? (s_tdata - prev_range_reg)
                                             : (prev_range_reg - s_tdata);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                mul_a = CFG_W'(diff);
                mul_b = CFG_W'(diff);
            end
            S_AB:
            begin
                mul_a = CFG_W'(prev_range_reg);
                mul_b = CFG_W'(r_reg);
            end
            S_CROSS:
            begin
                mul_a = ab_reg;
                mul_b = cosf_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign dist_sq = {1'b0, sq_reg} + {1'b0, cross_reg};

    assign emit     = kept || last_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = (state_reg == S_DECIDE) && (!emit || out_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_AB;
            S_AB:     state_next = S_CROSS;
            S_CROSS:  state_next = S_DECIDE;
            S_DECIDE: if (commit) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // segment decision for the beam in hand
    always_comb
    begin
        join_ok         = (beam_index_reg != '0) && prev_ok_reg && ok_reg
                          && (dist_sq < {1'b0, thresh_reg});
        in_segment_next = in_segment_reg;
        open_start_next = open_start_reg;
        pair_count_next = pair_count_reg;
        kept            = 1'b0;
        k_first         = '0;
        k_final         = '0;
        k_pairs         = '0;

        if (beam_index_reg != '0)
        begin
            if (join_ok)
            begin
                if (!in_segment_reg)
                begin
                    in_segment_next = 1'b1;
                    open_start_next = beam_index_reg - 1'b1;
                    pair_count_next = IDX_W'(1);
                end
                else if (pair_count_reg < PAIR_MAX)
                begin
                    pair_count_next = pair_count_reg + 1'b1;
                end
            end
            else if (in_segment_reg)
            begin
                if (pair_count_reg > min_pairs_reg)
                begin
                    kept    = 1'b1;
                    k_first = open_start_reg;
                    k_final = beam_index_reg - 1'b1;
                    k_pairs = pair_count_reg;
                end
                in_segment_next = 1'b0;
                open_start_next = '0;
                pair_count_next = '0;
            end
        end

        // scan end: open segment ends at the final beam itself
        if (last_reg && in_segment_next)
        begin
            if (pair_count_next > min_pairs_reg)
            begin
                kept    = 1'b1;
                k_first = open_start_next;
                k_final = beam_index_reg;
                k_pairs = pair_count_next;
            end
            in_segment_next = 1'b0;
        end

        if (last_reg)
        begin
            prev_range_next = '0;
            prev_ok_next    = 1'b0;
            beam_index_next = '0;
            in_segment_next = 1'b0;
            open_start_next = '0;
            pair_count_next = '0;
        end
        else
        begin
            prev_range_next = r_reg;
            prev_ok_next    = ok_reg;
            beam_index_next = (beam_index_reg < BEAM_LAST) ? beam_index_reg + 1'b1
                                                          : beam_index_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            min_pairs_reg <= MINPR_RESET;
            cosf_reg      <= COSF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIST_SQ_THRESHOLD:   thresh_reg    <= cfg_data;
                CFG_MIN_PAIRS:           min_pairs_reg <= cfg_data[IDX_W-1:0];
                CFG_TWICE_ONE_MINUS_COS: cosf_reg      <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            r_reg    <= s_tdata;
            ok_reg   <= s_tuser;
            last_reg <= s_tlast;
            sq_reg   <= mul_p[CFG_W-1:0];
        end
        if (state_reg == S_AB)
        begin
            ab_reg <= mul_p[CFG_W-1:0];
        end
        if (state_reg == S_CROSS)
        begin
            cross_reg <= mul_p[2*CFG_W-1:CFG_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_range_reg <= '0;
            prev_ok_reg    <= 1'b0;
            beam_index_reg <= '0;
            in_segment_reg <= 1'b0;
            open_start_reg <= '0;
            pair_count_reg <= '0;
        end
        else if (commit)
        begin
            prev_range_reg <= prev_range_next;
            prev_ok_reg    <= prev_ok_next;
            beam_index_reg <= beam_index_next;
            in_segment_reg <= in_segment_next;
            open_start_reg <= open_start_next;
            pair_count_reg <= pair_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && emit)
        begin
            out_data_reg <= {7'd0, k_pairs, IDX_W'(k_final), IDX_W'(k_first)};
            out_user_reg <= kept;
            out_last_reg <= last_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a beam while one was in flight");

    a_no_pairs_outside: assert property (@(posedge clk) disable iff (!rst_n)
        !in_segment_reg |-> (pair_count_reg == '0))
        else $error("pair count left over outside a segment");

    a_start_before_index: assert property (@(posedge clk) disable iff (!rst_n)
        in_segment_reg |-> (open_start_reg < beam_index_reg))
        else $error("open segment start not before current beam");

    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DECIDE))
        else $error("result word raised outside the decide step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !(commit && emit))
        else $error("pending result word overwritten");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for scan_breakpoint_segmenter_core: streams beams, predicts segment words.
// Depends on sbseg_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;
    import sbseg_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               range_valid;
        logic               scan_last;
    } beam_t;

    typedef struct packed {
        logic             seg_valid;
        logic [IDX_W-1:0] seg_first;
        logic [IDX_W-1:0] seg_final;
        logic [IDX_W-1:0] seg_pairs;
        logic             scan_done;
    } seg_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [RANGE_W-1:0]    s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    scan_breakpoint_segmenter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Mirror of the block: registers and per-scan state
    logic [CFG_W-1:0]   thr_mm2 = THRESH_RESET;
    logic [IDX_W-1:0]   pairs_floor = MINPR_RESET;
    logic [CFG_W-1:0]   cos_factor = COSF_RESET;
    logic [RANGE_W-1:0] last_range = '0;
    logic               last_ok = 1'b0;
    logic [BEAM_W-1:0]  idx_now = '0;
    logic               seg_open = 1'b0;
    logic [IDX_W-1:0]   seg_start = '0;
    logic [IDX_W-1:0]   seg_pairs_cnt = '0;

    beam_t     beam_backlog[$];
    seg_word_t seg_due[$];

    int  beams_queued = 0;
    int  beams_taken = 0;
    int  words_seen = 0;
    int  kept_seen = 0;
    int  scans_seen = 0;
    int  mismatches = 0;
    int  quiet = 0;
    int  beam_wait = 0;
    int  out_wait = 0;
    logic steady = 1'b0;
    logic beam_taken = 1'b0;
    logic word_taken = 1'b0;

    // Updates the mirror state for one beam; returns 1 when the beam yields a word.
    function automatic logic segment_beam(input beam_t b, output seg_word_t w);
        logic [RANGE_W-1:0] dr;
        logic [31:0]        rr;
        logic [63:0]        dsq;
        logic               linked;
        logic               kept;
        kept = 1'b0;
        w = '0;
        if (idx_now != '0) begin
            dr = (b.range_mm > last_range) ? b.range_mm - last_range : last_range - b.range_mm;
            rr = last_range * b.range_mm;
            // cross term: floor(r1*r2*factor / 2^32), sum may exceed 32 bits
            dsq = 64'(dr) * 64'(dr) + ((64'(rr) * 64'(cos_factor)) >> 32);
            linked = last_ok && b.range_valid && (dsq < 64'(thr_mm2));
            if (linked) begin
                if (!seg_open) begin
                    seg_open = 1'b1;
                    seg_start = idx_now - 1'b1;
                    seg_pairs_cnt = IDX_W'(1);
                end
                else if (seg_pairs_cnt != PAIR_MAX) begin
                    seg_pairs_cnt = seg_pairs_cnt + 1'b1;
                end
            end
            else if (seg_open) begin
                if (seg_pairs_cnt > pairs_floor) begin
                    kept = 1'b1;
                    w.seg_first = seg_start;
                    w.seg_final = idx_now - 1'b1;
                    w.seg_pairs = seg_pairs_cnt;
                end
                seg_open = 1'b0;
                seg_start = '0;
                seg_pairs_cnt = '0;
            end
        end
        // scan end closes an open segment on the final beam itself
        if (b.scan_last && seg_open) begin
            if (seg_pairs_cnt > pairs_floor) begin
                kept = 1'b1;
                w.seg_first = seg_start;
                w.seg_final = idx_now;
                w.seg_pairs = seg_pairs_cnt;
            end
            seg_open = 1'b0;
        end
        if (b.scan_last) begin
            last_range = '0;
            last_ok = 1'b0;
            idx_now = '0;
            seg_open = 1'b0;
            seg_start = '0;
            seg_pairs_cnt = '0;
        end
        else begin
            last_range = b.range_mm;
            last_ok = b.range_valid;
            if (idx_now != BEAM_LAST)
                idx_now = idx_now + 1'b1;
        end
        w.seg_valid = kept;
        w.scan_done = b.scan_last;
        return kept || b.scan_last;
    endfunction

    function automatic int draw_wait();
        if (steady)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
    endfunction

    // Beam driver
    always @(negedge clk) begin
        beam_t nxt;
        if (rst_n && (!s_tvalid || beam_taken)) begin
            if (beam_wait != 0) begin
                s_tvalid <= 1'b0;
                beam_wait <= beam_wait - 1;
            end
            else if (beam_backlog.size() != 0) begin
                nxt = beam_backlog.pop_front();
                s_tdata <= nxt.range_mm;
                s_tuser <= nxt.range_valid;
                s_tlast <= nxt.scan_last;
                s_tvalid <= 1'b1;
                beam_wait <= draw_wait();
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stall drawn after each word taken
    always @(negedge clk) begin
        int hold;
        if (rst_n) begin
            hold = word_taken ? draw_wait() : out_wait;
            if (hold != 0) begin
                m_tready <= 1'b0;
                out_wait <= hold - 1;
            end
            else begin
                m_tready <= 1'b1;
                out_wait <= 0;
            end
        end
    end

    // Monitor: predicts on each accepted beam, checks each accepted word
    always @(posedge clk) begin
        beam_t     seen;
        seg_word_t want;
        beam_taken <= rst_n && s_tvalid && s_tready;
        word_taken <= rst_n && m_tvalid && m_tready;
        if (rst_n && s_tvalid && s_tready) begin
            seen.range_mm = s_tdata;
            seen.range_valid = s_tuser;
            seen.scan_last = s_tlast;
            beams_taken++;
            if (s_tlast)
                scans_seen++;
            if (segment_beam(seen, want))
                seg_due = {seg_due, want};
        end
        if (rst_n && m_tvalid && m_tready) begin
            words_seen++;
            if (seg_due.size() == 0) begin
                $error("word with nothing pending: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else begin
                want = seg_due.pop_front();
                if (want.seg_valid)
                    kept_seen++;
                if (m_tuser !== want.seg_valid) begin
                    $error("seg_valid: expected %0d, got %0d", want.seg_valid, m_tuser);
                    mismatches++;
                end
                if (m_tdata[10:0] !== want.seg_first) begin
                    $error("seg_first: expected %0d, got %0d", want.seg_first, m_tdata[10:0]);
                    mismatches++;
                end
                if (m_tdata[21:11] !== want.seg_final) begin
                    $error("seg_final: expected %0d, got %0d", want.seg_final, m_tdata[21:11]);
                    mismatches++;
                end
                if (m_tdata[32:22] !== want.seg_pairs) begin
                    $error("seg_pairs: expected %0d, got %0d", want.seg_pairs, m_tdata[32:22]);
                    mismatches++;
                end
                if (m_tlast !== want.scan_done) begin
                    $error("scan_done: expected %0d, got %0d", want.scan_done, m_tlast);
                    mismatches++;
                end
                if (m_tdata[39:33] !== '0) begin
                    $error("tdata pad: expected 0, got %h", m_tdata[39:33]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d words still due",
                         QUIET_LIMIT, seg_due.size());
                $display("scan_breakpoint_segmenter_core test failed");
                $finish;
            end
        end
    end

    task automatic push_beam(input int r, input logic ok, input logic fin);
        beam_t b;
        b.range_mm = 16'(r);
        b.range_valid = ok;
        b.scan_last = fin;
        beam_backlog = {beam_backlog, b};
        beams_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DIST_SQ_THRESHOLD:   thr_mm2 = val;
            CFG_MIN_PAIRS:           pairs_floor = val[IDX_W-1:0];
            CFG_TWICE_ONE_MINUS_COS: cos_factor = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Block idle: all beams taken, all words back, pipeline drained
    task automatic settle();
        while (beams_taken != beams_queued || seg_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One scan: a random walk in range with jumps and dropouts
    task automatic gen_scan();
        int len;
        int cur;
        int step_max;
        int roll;
        int r;
        case ($urandom_range(0, 9))
            0:       len = 1;
            1, 2:    len = $urandom_range(41, 200);
            default: len = $urandom_range(2, 40);
        endcase
        case ($urandom_range(0, 2))
            0:       cur = $urandom_range(0, 600);
            1:       cur = $urandom_range(500, 12000);
            default: cur = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
            0:       step_max = 0;
            1:       step_max = 40;
            2:       step_max = 400;
            default: step_max = 4000;
        endcase
        for (int k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                push_beam($urandom_range(0, 65535), 1'b0, k == len - 1);
            end
            else begin
                if (roll < 12) begin
                    cur = $urandom_range(0, 65535);
                end
                else begin
                    r = $urandom_range(0, 2 * step_max);
                    cur = cur + r - step_max;
                    if (cur < 0)
                        cur = 0;
                    if (cur > 65535)
                        cur = 65535;
                end
                push_beam(cur, 1'b1, k == len - 1);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] thr;
        logic [IDX_W-1:0] mp;
        logic [CFG_W-1:0] cf;
        int target;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values
        push_beam(0, 1'b1, 1'b1);                    // one-beam scan
        for (int k = 0; k < 8; k++)
            push_beam(1000 + 10 * k, 1'b1, 1'b0);   // seven joined pairs
        push_beam(1234, 1'b0, 1'b0);                 // invalid beam breaks it
        push_beam(65535, 1'b1, 1'b0);
        push_beam(65535, 1'b1, 1'b0);                // cross term alone too large
        push_beam(0, 1'b1, 1'b0);
        push_beam(0, 1'b1, 1'b0);
        push_beam(0, 1'b1, 1'b1);                    // short open segment at scan end
        for (int k = 0; k < 7; k++)
            push_beam(3000, 1'b1, k == 6);           // kept segment ends on final beam

        // Write to the unused register index is ignored
        settle();
        write_reg(CFG_SPARE_IDX, $urandom);

        for (int ph = 0; ph < 9; ph++) begin
            settle();
            case (ph)
                0: begin thr = THRESH_RESET;  mp = MINPR_RESET; cf = COSF_RESET; end
                1: begin thr = 32'd0;         mp = 11'd0;       cf = COSF_RESET; end
                2: begin thr = 32'hFFFF_FFFF; mp = PAIR_MAX;    cf = 32'hFFFF_FFFF; end
                3: begin thr = 32'd40000;     mp = 11'd0;       cf = COSF_RESET; end
                4: begin
                    thr = $urandom_range(0, 200000);
                    mp = IDX_W'($urandom_range(0, 8));
                    cf = $urandom_range(0, 400000);
                end
                5: begin thr = 32'd2500;      mp = 11'd3;       cf = 32'h8000_0000; end
                6: begin thr = 32'hFFFF_FFFF; mp = 11'd1;       cf = 32'hFFFF_FFFF; end
                7: begin thr = 32'd1000000;   mp = 11'd2;       cf = 32'd327000; end
                default: begin thr = 32'd1;   mp = 11'd0;       cf = 32'd0; end
            endcase
            write_reg(CFG_DIST_SQ_THRESHOLD, thr);
            // upper bits of the min-pairs word are don't-care
            write_reg(CFG_MIN_PAIRS, {21'($urandom), mp});
            write_reg(CFG_TWICE_ONE_MINUS_COS, cf);
            steady = (ph % 4 == 3);
            target = beams_queued + 100;
            while (beams_queued < target)
                gen_scan();
        end
        settle();

        $display("%0d beams over %0d scans under 10 register settings", beams_taken, scans_seen);
        $display("%0d words checked, %0d of them kept segments", words_seen, kept_seen);
        if (mismatches == 0 && seg_due.size() == 0)
            $display("scan_breakpoint_segmenter_core test passed");
        else
            $display("scan_breakpoint_segmenter_core test failed");
        $finish;
    end

endmodule

FILE: scan_breakpoint_segmenter_core.f
rtl/sbseg_pkg.sv
rtl/scan_breakpoint_segmenter_core.sv
tb/tb_top.sv
